FILE: rtl/adsr_pkg.sv
// ---------------------------------------------------------------------------
// adsr_pkg
// Shared types, constants and register codes of the ADSR envelope generator.
// ---------------------------------------------------------------------------
package adsr_pkg;

	// Field widths fixed by the interface
	localparam int GATE_W     = 16;
	localparam int LEN_W      = 24;
	localparam int SUS_W      = 16;
	localparam int LEVEL_O_W  = 16;
	localparam int PHASE_W    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Defaults for the top-level parameters
	localparam int COUNT_WIDTH_DEF     = 32;
	localparam int LEVEL_FRAC_BITS_DEF = 15;

	// Register reset values
	localparam logic [LEN_W-1:0] ATTACK_RST  = 24'd441;
	localparam logic [LEN_W-1:0] DECAY_RST   = 24'd4410;
	localparam logic [SUS_W-1:0] SUSTAIN_RST = 16'd16384;
	localparam logic [LEN_W-1:0] RELEASE_RST = 24'd4410;

	// Gate value forced by a manual press
	localparam logic signed [GATE_W-1:0] GATE_FULL = 16'sh7FFF;

	// Envelope phase codes
	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK  = 2'd0,
		CFG_DECAY   = 2'd1,
		CFG_SUSTAIN = 2'd2,
		CFG_RELEASE = 2'd3
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} seq_state_t;

	// Current register settings
	typedef struct packed {
		logic [LEN_W-1:0] attack;
		logic [LEN_W-1:0] decay;
		logic [SUS_W-1:0] sustain;
		logic [LEN_W-1:0] release_len;
	} cfg_t;

endpackage

FILE: rtl/adsr_envelope_generator.sv
// ---------------------------------------------------------------------------
// adsr_envelope_generator
// Each input passes the check and setup states; on a ramp the level then goes
// through the serial multiplier and the serial divider, while idle, sustain or
// a finished ramp skip both. One item at a time: a new input is taken only
// after the result is registered. Reset clears phase, counter and gate
// history and loads the register defaults.
// ---------------------------------------------------------------------------
module adsr_envelope_generator #(
	parameter int COUNT_WIDTH     = adsr_pkg::COUNT_WIDTH_DEF,
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [adsr_pkg::GATE_W-1:0]       s_tdata,   // [15:0] gate_sample
	input  logic                              s_tuser,   // [0] manual_press
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [adsr_pkg::LEVEL_O_W-1:0]    m_tdata,   // [15:0] envelope_level
	output logic [adsr_pkg::PHASE_W-1:0]      m_tuser,   // [2:0] phase
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import adsr_pkg::*;

	localparam int CW    = COUNT_WIDTH;
	localparam int F     = LEVEL_FRAC_BITS;
	localparam int LW    = F + 1;
	localparam int CMP_W = LW + SUS_W;
	localparam int PW    = LEN_W + LW;
	localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {F{1'b0}}};

	cfg_t cfg;

	seq_state_t state_q, state_d;
	phase_t     phase_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            rstart_q;
	logic signed [GATE_W-1:0] prev_gate_q;
	logic [LW-1:0]            lvl_q;

	logic                 m_tvalid_q;
	logic [LEVEL_O_W-1:0] m_tdata_q;
	logic [PHASE_W-1:0]   m_tuser_q;

	logic in_xfer;
	logic mul_start, mul_done, div_done;
	logic lvl_load, out_load;
	logic [LW-1:0] lvl_d;

	logic signed [GATE_W-1:0] gate;
	phase_t                   edge_phase, chk_phase;
	logic [CW-1:0]            edge_count, edge_rstart, chk_count;
	logic [CW-1:0]            ad_end, rel_end;

	logic [CMP_W-1:0] sus_wide;
	logic [LW-1:0]    sus_cl;
	logic [LEN_W-1:0] ramp_len;
	logic [CW-1:0]    ramp_base;
	logic [LW-1:0]    ramp_gain;
	logic [LW-1:0]    direct_lvl;
	logic [CW-1:0]    elapsed;
	logic             saturated;
	logic             ramp_phase;
	logic [PW-1:0]    mul_prod;
	logic [F-1:0]     div_quo;
	logic [LW-1:0]    quo_ext;
	logic [LW-1:0]    ramp_lvl;
	logic [LW+LEVEL_O_W-1:0] lvl_wide;

	adsr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	adsr_ser_mul #(
		.OPA_W (LEN_W),
		.OPB_W (LW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.opa     (elapsed[LEN_W-1:0]),
		.opb     (ramp_gain),
		.done    (mul_done),
		.product (mul_prod)
	);

	adsr_ser_div #(
		.DEN_W (LEN_W),
		.QUO_W (F)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_done),
		.num      (mul_prod[PW-2:0]),
		.den      (ramp_len),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_xfer = s_tvalid && s_tready;

	// Gate edges at the input transfer
	always_comb begin
		gate        = s_tuser ? GATE_FULL : $signed(s_tdata);
		edge_phase  = phase_q;
		edge_count  = count_q;
		edge_rstart = rstart_q;
		if ((gate > prev_gate_q) && (phase_q == PH_IDLE)) begin
			edge_count = '0;
			edge_phase = PH_ATTACK;
		end
		if (gate < prev_gate_q) begin
			edge_phase  = PH_RELEASE;
			edge_rstart = edge_count;
		end
	end

	// Phase end checks, in attack, decay, release order
	assign ad_end  = CW'(cfg.attack) + CW'(cfg.decay);
	assign rel_end = rstart_q + CW'(cfg.release_len);

	always_comb begin
		chk_phase = phase_q;
		chk_count = count_q;
		if ((chk_phase == PH_ATTACK) && (count_q == CW'(cfg.attack)))
			chk_phase = PH_DECAY;
		if ((chk_phase == PH_DECAY) && (count_q == ad_end))
			chk_phase = PH_SUSTAIN;
		if ((chk_phase == PH_RELEASE) && (count_q == rel_end)) begin
			chk_phase = PH_IDLE;
			chk_count = '0;
		end
	end

	// Ramp operands and saturated levels for the current phase
	assign sus_wide = CMP_W'(cfg.sustain);
	assign sus_cl   = (sus_wide > CMP_W'(LEVEL_ONE)) ? LEVEL_ONE : sus_wide[LW-1:0];

	always_comb begin
		ramp_len   = cfg.attack;
		ramp_base  = '0;
		ramp_gain  = LEVEL_ONE;
		direct_lvl = '0;
		ramp_phase = 1'b0;
		unique case (phase_q)
			PH_ATTACK: begin
				ramp_phase = 1'b1;
				direct_lvl = LEVEL_ONE;
			end
			PH_DECAY: begin
				ramp_len   = cfg.decay;
				ramp_base  = CW'(cfg.attack);
				ramp_gain  = LEVEL_ONE - sus_cl;
				direct_lvl = sus_cl;
				ramp_phase = 1'b1;
			end
			PH_SUSTAIN: begin
				direct_lvl = sus_cl;
			end
			PH_RELEASE: begin
				ramp_len   = cfg.release_len;
				ramp_base  = rstart_q;
				ramp_gain  = sus_cl;
				ramp_phase = 1'b1;
			end
			default: begin
				direct_lvl = '0;
			end
		endcase
	end

	assign elapsed   = count_q - ramp_base;
	assign saturated = (ramp_len == '0) || (elapsed >= CW'(ramp_len));

	// Turn the quotient into a level
	assign quo_ext = LW'(div_quo);
	always_comb begin
		unique case (phase_q)
			PH_DECAY:   ramp_lvl = LEVEL_ONE - quo_ext;
			PH_RELEASE: ramp_lvl = sus_cl - quo_ext;
			default:    ramp_lvl = quo_ext;
		endcase
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and step controls
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mul_start = 1'b0;
		lvl_load  = 1'b0;
		lvl_d     = direct_lvl;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (ramp_phase && !saturated) begin
					mul_start = 1'b1;
					state_d   = ST_MUL;
				end else begin
					lvl_load = 1'b1;
					state_d  = ST_FIN;
				end
			end
			ST_MUL: begin
				if (mul_done)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					lvl_load = 1'b1;
					lvl_d    = ramp_lvl;
					state_d  = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Envelope state: edges on transfer, end checks, then advance the counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			rstart_q    <= '0;
			prev_gate_q <= '0;
		end else if (in_xfer) begin
			phase_q     <= edge_phase;
			count_q     <= edge_count;
			rstart_q    <= edge_rstart;
			prev_gate_q <= gate;
		end else if (state_q == ST_CHECK) begin
			phase_q <= chk_phase;
			count_q <= chk_count;
		end else if ((state_q == ST_SETUP) && (phase_q != PH_IDLE)) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Hold the computed level
	always_ff @(posedge clk) begin
		if (lvl_load)
			lvl_q <= lvl_d;
	end

	// Output register
	assign lvl_wide = (LW + LEVEL_O_W)'(lvl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= lvl_wide[LEVEL_O_W-1:0];
			m_tuser_q <= phase_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Level never exceeds full scale
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_load |=> (lvl_q <= LEVEL_ONE))
		else $error("envelope level above full scale");

	// Counter rests at zero while idle
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SETUP) && (phase_q == PH_IDLE)) |-> (count_q == '0))
		else $error("counter not zero in idle phase");

	// Product hand-off goes straight to the divider
	a_mul_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |=> (state_q == ST_DIV))
		else $error("multiplier finished outside ramp step");

	// Idle results carry a zero level
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (phase_q == PH_IDLE)) |=> (m_tdata == '0))
		else $error("nonzero level in idle phase");

endmodule

FILE: rtl/adsr_cfg_regs.sv
// ---------------------------------------------------------------------------
// adsr_cfg_regs
// Configuration register file: phase lengths and sustain level.
// ---------------------------------------------------------------------------
module adsr_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output adsr_pkg::cfg_t                    cfg
);
	import adsr_pkg::*;

	cfg_t     cfg_q;
	cfg_reg_t reg_sel;

	assign cfg_ready = 1'b1;
	assign reg_sel   = cfg_reg_t'(cfg_index);
	assign cfg       = cfg_q;

	// Update the addressed register on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack      <= ATTACK_RST;
			cfg_q.decay       <= DECAY_RST;
			cfg_q.sustain     <= SUSTAIN_RST;
			cfg_q.release_len <= RELEASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_sel)
				CFG_ATTACK:  cfg_q.attack      <= cfg_data[LEN_W-1:0];
				CFG_DECAY:   cfg_q.decay       <= cfg_data[LEN_W-1:0];
				CFG_SUSTAIN: cfg_q.sustain     <= cfg_data[SUS_W-1:0];
				CFG_RELEASE: cfg_q.release_len <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

endmodule

FILE: rtl/adsr_ser_mul.sv
// ---------------------------------------------------------------------------
// adsr_ser_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module adsr_ser_mul #(
	parameter int OPA_W = 24,
	parameter int OPB_W = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [OPA_W-1:0]         opa,
	input  logic [OPB_W-1:0]         opb,
	output logic                     done,
	output logic [OPA_W+OPB_W-1:0]   product
);
	localparam int PW    = OPA_W + OPB_W;
	localparam int CNT_W = $clog2(OPB_W + 1);

	logic [PW-1:0]    prod_q;
	logic [OPA_W-1:0] opa_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [OPA_W:0]   sum;

	// Add the multiplicand into the upper half when the low bit is set
	assign sum = {1'b0, prod_q[PW-1:OPB_W]} + (prod_q[0] ? {1'b0, opa_q} : '0);

	assign done    = done_q;
	assign product = prod_q;

	// Hold operands, shift the partial product right each step
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PW'(opb);
			opa_q  <= opa;
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[OPB_W-1:1]};
		end
	end

	// Count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(OPB_W);
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/adsr_ser_div.sv
// ---------------------------------------------------------------------------
// adsr_ser_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUO_W bits.
// ---------------------------------------------------------------------------
module adsr_ser_div #(
	parameter int DEN_W = 24,
	parameter int QUO_W = 15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DEN_W+QUO_W-1:0]   num,
	input  logic [DEN_W-1:0]         den,
	output logic                     done,
	output logic [QUO_W-1:0]         quotient
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// Bring down the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	assign done     = done_q;
	assign quotient = quo_q;

	// Shift quotient bits in from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DEN_W+QUO_W-1:QUO_W];
			quo_q <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	// Count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUO_W);
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADSR envelope generator. A short table of
// known samples and register settings runs first, then phases of random
// note sequences and gate noise under changing settings and flow-control
// pressure. Every result is compared with its table value or with an in-bench envelope predictor.
// ---------------------------------------------------------------------------
module tb_top;
	import adsr_pkg::*;

	localparam int CNT_W        = COUNT_WIDTH_DEF;
	localparam int FRAC         = LEVEL_FRAC_BITS_DEF;
	localparam longint unsigned LEVEL_ONE = 64'd1 << FRAC;
	localparam int NUM_SETTINGS = 14;
	localparam int TAIL_CYCLES  = 2*FRAC + 10;

	typedef struct packed {
		logic [LEVEL_O_W-1:0] level;
		phase_t               phase;
	} env_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_SETTINGS} row_kind_t;

	// One line of the directed table: a sample or a full register setting
	typedef struct packed {
		row_kind_t            kind;
		logic [GATE_W-1:0]    gate;
		logic                 manual;
		logic                 known;
		logic [LEVEL_O_W-1:0] level;
		phase_t               phase;
		logic [LEN_W-1:0]     atk;
		logic [LEN_W-1:0]     dec;
		logic [SUS_W-1:0]     sus;
		logic [LEN_W-1:0]     rel;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [GATE_W-1:0]     s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [LEVEL_O_W-1:0]  m_tdata;
	logic [PHASE_W-1:0]    m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor copy of registers and envelope state
	logic [LEN_W-1:0]        atk_len = ATTACK_RST;
	logic [LEN_W-1:0]        dec_len = DECAY_RST;
	logic [SUS_W-1:0]        sus_lvl = SUSTAIN_RST;
	logic [LEN_W-1:0]        rel_len = RELEASE_RST;
	phase_t                  env_phase = PH_IDLE;
	logic [CNT_W-1:0]        elapsed = '0;
	logic [CNT_W-1:0]        release_mark = '0;
	logic signed [GATE_W-1:0] last_gate = '0;

	env_result_t expected_env[$];
	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int          errors = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          cfg_writes = 0;
	int          settings_count = 0;
	int          phase_hits[8];

	adsr_envelope_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Fail the run if it hangs
	initial begin
		#(64'd10_000_000);
		$display("FAIL adsr_envelope_generator");
		$finish;
	end

	task automatic flag_error(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		errors++;
	endtask

	// Advance the envelope by one sample and return the level and phase
	function automatic env_result_t advance_envelope(input logic [GATE_W-1:0] gate_in,
			input logic manual);
		logic signed [GATE_W-1:0] g;
		logic [CNT_W-1:0]         span;
		longint unsigned          sus;
		longint unsigned          lvl;
		env_result_t              res;
		g = manual ? GATE_FULL : $signed(gate_in);
		// rising gate restarts only from idle; falling gate releases from anywhere
		if (g > last_gate && env_phase == PH_IDLE) begin
			elapsed = '0;
			env_phase = PH_ATTACK;
		end
		if (g < last_gate) begin
			env_phase = PH_RELEASE;
			release_mark = elapsed;
		end
		// end checks on exact matches, zero lengths fall through at once
		if (env_phase == PH_ATTACK && elapsed == CNT_W'(atk_len))
			env_phase = PH_DECAY;
		if (env_phase == PH_DECAY && elapsed == CNT_W'(atk_len) + CNT_W'(dec_len))
			env_phase = PH_SUSTAIN;
		if (env_phase == PH_RELEASE && elapsed == release_mark + CNT_W'(rel_len)) begin
			env_phase = PH_IDLE;
			elapsed = '0;
		end
		sus = (sus_lvl > LEVEL_ONE) ? LEVEL_ONE : 64'(sus_lvl);
		lvl = 0;
		case (env_phase)
			PH_ATTACK: begin
				if (atk_len == 0 || elapsed >= atk_len)
					lvl = LEVEL_ONE;
				else
					lvl = (64'(elapsed) << FRAC) / atk_len;
			end
			PH_DECAY: begin
				span = elapsed - CNT_W'(atk_len);
				if (dec_len == 0 || span >= dec_len)
					lvl = sus;
				else
					lvl = LEVEL_ONE - ((LEVEL_ONE - sus) * span) / dec_len;
			end
			PH_SUSTAIN: lvl = sus;
			PH_RELEASE: begin
				span = elapsed - release_mark;
				if (rel_len == 0 || span >= rel_len)
					lvl = 0;
				else
					lvl = sus - (sus * span) / rel_len;
			end
			default: lvl = 0;
		endcase
		if (env_phase != PH_IDLE)
			elapsed = elapsed + 1'b1;
		last_gate = g;
		res.level = lvl[LEVEL_O_W-1:0];
		res.phase = env_phase;
		return res;
	endfunction

	// Drain, then write all four registers in random order
	task automatic program_settings(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] d,
			input logic [SUS_W-1:0] s, input logic [LEN_W-1:0] r);
		cfg_reg_t             order[4];
		cfg_reg_t             tmp;
		int                   j;
		logic [CFG_DATA_W-1:0] val;
		s_tvalid <= 1'b0;
		while (expected_env.size() != 0)
			@(posedge clk);
		order = '{CFG_ATTACK, CFG_DECAY, CFG_SUSTAIN, CFG_RELEASE};
		for (int i = 3; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < 4; i++) begin
			case (order[i])
				CFG_ATTACK:  val = a;
				CFG_DECAY:   val = d;
				// upper bits of the sustain write carry junk
				CFG_SUSTAIN: val = {8'($urandom), s};
				default:     val = r;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= val;
			do @(posedge clk); while (!cfg_ready);
			case (order[i])
				CFG_ATTACK:  atk_len = a;
				CFG_DECAY:   dec_len = d;
				CFG_SUSTAIN: sus_lvl = s;
				default:     rel_len = r;
			endcase
			cfg_writes++;
		end
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	// Transfer one sample and queue its expected result
	task automatic send_sample(input logic [GATE_W-1:0] gate, input logic manual,
			input logic known, input env_result_t known_res);
		int          gap;
		bit          hold;
		env_result_t res;
		gap = 0;
		while (gap < 60 && $urandom_range(0, 99) < src_idle_pct)
			gap++;
		hold = ($urandom_range(0, 149) == 0);
		if (gap != 0 || hold) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			// occasionally hold off until every result is back
			if (hold)
				do @(posedge clk); while (expected_env.size() != 0);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= gate;
		s_tuser  <= manual;
		do @(posedge clk); while (!s_tready);
		res = advance_envelope(gate, manual);
		expected_env.push_back(known ? known_res : res);
		items_sent++;
	endtask

	function automatic stim_row_t known_row(input logic [GATE_W-1:0] g, input logic m,
			input logic [LEVEL_O_W-1:0] lvl, input phase_t ph);
		stim_row_t row;
		row = '0;
		row.kind = ROW_SAMPLE;
		row.gate = g;
		row.manual = m;
		row.known = 1'b1;
		row.level = lvl;
		row.phase = ph;
		return row;
	endfunction

	function automatic stim_row_t ramp_row(input logic [GATE_W-1:0] g, input logic m);
		stim_row_t row;
		row = '0;
		row.kind = ROW_SAMPLE;
		row.gate = g;
		row.manual = m;
		return row;
	endfunction

	function automatic stim_row_t setting_row(input logic [LEN_W-1:0] a,
			input logic [LEN_W-1:0] d, input logic [SUS_W-1:0] s, input logic [LEN_W-1:0] r);
		stim_row_t row;
		row = '0;
		row.kind = ROW_SETTINGS;
		row.atk = a;
		row.dec = d;
		row.sus = s;
		row.rel = r;
		return row;
	endfunction

	function automatic logic [LEN_W-1:0] long_length();
		return $urandom_range(0, 1) ? {LEN_W{1'b1}} : LEN_W'($urandom);
	endfunction

	// Receiver stall pattern
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		env_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			phase_hits[m_tuser]++;
			if (expected_env.size() == 0) begin
				flag_error($sformatf("result level %0d phase %0d with nothing expected",
					m_tdata, m_tuser));
			end else begin
				want = expected_env.pop_front();
				if (m_tdata !== want.level)
					flag_error($sformatf("result %0d: level %0d, expected %0d",
						results_seen, m_tdata, want.level));
				if (m_tuser !== want.phase)
					flag_error($sformatf("result %0d: phase %0d, expected %0d",
						results_seen, m_tuser, want.phase));
			end
		end
	end

	initial begin
		stim_row_t              directed[$];
		env_result_t            kr;
		logic signed [GATE_W-1:0] lo;
		logic signed [GATE_W-1:0] hi;
		logic signed [GATE_W-1:0] tmp;
		logic [LEN_W-1:0]       a;
		logic [LEN_W-1:0]       d;
		logic [LEN_W-1:0]       r;
		logic [SUS_W-1:0]       s;
		logic                   press;
		bit                     heavy;
		int                     target;
		int                     phase_start;
		int                     hold_n;
		int                     rest_n;

		// Directed table: defaults after reset, then zero lengths and level extremes
		directed.push_back(known_row(16'h0000, 1'b0, 16'd0, PH_IDLE));
		directed.push_back(known_row(16'h7FFF, 1'b0, 16'd0, PH_ATTACK));
		directed.push_back(ramp_row(16'h7FFF, 1'b0));
		directed.push_back(known_row(16'h8000, 1'b0, 16'd16384, PH_RELEASE));
		// release shortened below the elapsed count: ramp saturates at zero
		directed.push_back(setting_row(24'd441, 24'd4410, 16'd16384, 24'd0));
		directed.push_back(known_row(16'h8000, 1'b0, 16'd0, PH_RELEASE));
		directed.push_back(known_row(16'h0000, 1'b0, 16'd0, PH_RELEASE));
		// fresh fall with zero release drops straight back to idle
		directed.push_back(known_row(16'h8000, 1'b0, 16'd0, PH_IDLE));
		// zero attack and decay: manual press lands in sustain at full scale
		directed.push_back(setting_row(24'd0, 24'd0, 16'd32768, 24'd3));
		directed.push_back(known_row(16'h8000, 1'b1, 16'd32768, PH_SUSTAIN));
		directed.push_back(known_row(16'h8000, 1'b0, 16'd32768, PH_RELEASE));
		directed.push_back(ramp_row(16'h8000, 1'b0));
		directed.push_back(ramp_row(16'h8000, 1'b0));
		directed.push_back(known_row(16'h8000, 1'b0, 16'd0, PH_IDLE));
		// full short cycle with zero sustain
		directed.push_back(setting_row(24'd4, 24'd4, 16'd0, 24'd2));
		directed.push_back(known_row(16'h0001, 1'b0, 16'd0, PH_ATTACK));
		directed.push_back(ramp_row(16'h0001, 1'b0));
		directed.push_back(ramp_row(16'h0002, 1'b0));
		directed.push_back(ramp_row(16'h0002, 1'b0));
		directed.push_back(known_row(16'h0002, 1'b0, 16'd32768, PH_DECAY));
		directed.push_back(ramp_row(16'h0002, 1'b0));
		directed.push_back(ramp_row(16'h0002, 1'b0));
		directed.push_back(ramp_row(16'h0002, 1'b0));
		directed.push_back(known_row(16'h0002, 1'b0, 16'd0, PH_SUSTAIN));
		directed.push_back(known_row(16'h8000, 1'b0, 16'd0, PH_RELEASE));
		directed.push_back(ramp_row(16'h8000, 1'b0));
		directed.push_back(known_row(16'h8000, 1'b0, 16'd0, PH_IDLE));

		foreach (phase_hits[i])
			phase_hits[i] = 0;

		// Reset once
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed[i]) begin
			if (directed[i].kind == ROW_SETTINGS) begin
				program_settings(directed[i].atk, directed[i].dec, directed[i].sus,
					directed[i].rel);
			end else begin
				kr.level = directed[i].level;
				kr.phase = directed[i].phase;
				send_sample(directed[i].gate, directed[i].manual, directed[i].known, kr);
			end
		end

		// Random phases: mostly short envelopes, a few with long random or maximum lengths
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			heavy = (p % 5 == 4);
			if (heavy) begin
				a = long_length();
				d = long_length();
				r = long_length();
				target = 40;
			end else begin
				a = LEN_W'($urandom_range(0, 12));
				d = LEN_W'($urandom_range(0, 12));
				r = LEN_W'($urandom_range(0, 12));
				target = 120;
			end
			case ($urandom_range(0, 4))
				0:       s = 16'd0;
				1:       s = 16'd32768;
				2:       s = 16'hFFFF;
				3:       s = SUS_W'($urandom_range(0, 32768));
				default: s = 16'($urandom);
			endcase
			program_settings(a, d, s, r);
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 72; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 72; end
				default: begin src_idle_pct = 7; sink_stall_pct = 7; end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < target) begin
				if ($urandom_range(0, 99) < 75) begin
					// note: low, held high (or pressed), then low through release
					lo = $signed(16'($urandom));
					hi = $signed(16'($urandom));
					if (hi < lo) begin
						tmp = hi;
						hi = lo;
						lo = tmp;
					end
					press = ($urandom_range(0, 3) == 0);
					hold_n = $urandom_range(0, 30);
					rest_n = $urandom_range(0, 30);
					send_sample(lo, 1'b0, 1'b0, '0);
					repeat (hold_n + 1)
						send_sample(press ? 16'($urandom) : hi, press, 1'b0, '0);
					repeat (rest_n)
						send_sample(lo, 1'b0, 1'b0, '0);
				end else begin
					repeat ($urandom_range(1, 4))
						send_sample(16'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);
				end
			end
		end

		// Drain and let any stray result show up
		s_tvalid <= 1'b0;
		while (expected_env.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d samples over %0d register settings (%0d writes), %0d results.",
			items_sent, settings_count, cfg_writes, results_seen);
		$display("Results by phase: idle %0d, attack %0d, decay %0d, sustain %0d, release %0d",
			phase_hits[PH_IDLE], phase_hits[PH_ATTACK], phase_hits[PH_DECAY],
			phase_hits[PH_SUSTAIN], phase_hits[PH_RELEASE]);
		if (errors == 0)
			$display("PASS adsr_envelope_generator");
		else
			$display("FAIL adsr_envelope_generator");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/adsr_pkg.sv
rtl/adsr_cfg_regs.sv
rtl/adsr_ser_mul.sv
rtl/adsr_ser_div.sv
rtl/adsr_envelope_generator.sv
tb/tb_top.sv
